[rtl/pwcs_pkg.sv]
// Shared types, codes and constants of the pulse-width command serializer.
// Used by the serializer top level, the line checker and the testbench; no dependencies.
package pwcs_pkg;

   // Frame store depth default and fixed frame bytes
   localparam int MAX_FRAME_BYTES = 4;
   localparam int FRAME_SLOTS     = 4;   // lead, two data bytes, terminator
   localparam logic [7:0] LEAD_BYTE = 8'h0A;
   localparam logic [7:0] PLAY_END  = 8'h0B;
   localparam logic [7:0] CMD_END   = 8'h0C;

   // Register reset values
   localparam logic [15:0] TICKS_PER_UNIT_RST  = 16'd200;
   localparam logic [7:0]  LEAD_HIGH_UNITS_RST = 8'd5;
   localparam logic [7:0]  LEAD_LOW_UNITS_RST  = 8'd15;
   localparam logic [7:0]  LONG_UNITS_RST      = 8'd3;
   localparam logic [7:0]  SHORT_UNITS_RST     = 8'd1;

   // Command codes
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   // Data byte counts
   localparam logic [1:0] COUNT_ONE = 2'd1;
   localparam logic [1:0] COUNT_TWO = 2'd2;

   // Terminator kinds
   localparam logic [1:0] END_COMMAND = 2'd0;
   localparam logic [1:0] END_PLAY    = 2'd1;

   // Register indexes
   typedef enum logic [2:0] {
      REG_TICKS_PER_UNIT  = 3'd0,
      REG_LEAD_HIGH_UNITS = 3'd1,
      REG_LEAD_LOW_UNITS  = 3'd2,
      REG_LONG_UNITS      = 3'd3,
      REG_SHORT_UNITS     = 3'd4
   } reg_index_type;

   // Line phases
   typedef enum logic [4:0] {
      PH_IDLE      = 5'b00001,
      PH_LEAD_HIGH = 5'b00010,
      PH_LEAD_LOW  = 5'b00100,
      PH_BIT_HIGH  = 5'b01000,
      PH_BIT_LOW   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [1:0] byte_count;
      logic [1:0] end_kind;
   } req_payload_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic frame_done;
      logic start_rejected;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0]  index;
      logic [15:0] data;
   } csr_payload_type;

   // A zero count behaves as one
   function automatic logic [15:0] at_least_one(input logic [15:0] v);
      at_least_one = (v == 16'd0) ? 16'd1 : v;
   endfunction

endpackage

[rtl/pwcs_chan_if.sv]
// Valid/ready channel carrying one payload item per handshake.
// Payload type comes from pwcs_pkg at instantiation.
interface pwcs_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/pulse_width_command_serializer_unit.sv]
// Pulse-width command serializer: single-wire frame transmitter.
// Depends on pwcs_pkg and pwcs_chan_if.
//
// Usage:
//   req_if carries items: a tick (cmd 0) advances time by one tick, a start
//   (cmd 1) loads a frame of 0x0A, up to two data bytes and an optional
//   terminator. Each item gives exactly one result on rsp_if: the wire
//   level after the item, busy, frame done and start rejected flags.
//   csr_if writes the five timing registers; write them only while idle.
//   Each result is registered (in the skid register while rsp_if stalls).
//   Throughput: one item per cycle while req_if.ready is high; the whole
//   update of counters, phase and frame store happens in the accept cycle,
//   gated by the tick prescaler and unit counter compare.
//   A two-entry output buffer (result register plus skid register) lets
//   the block take one more item while rsp_if is stalled; req_if.ready
//   drops only when both entries hold results.
//   Reset (synchronous, active high) returns the block to idle with the
//   wire high, loads register defaults and empties the output buffer.
//   The csr channel is always ready.
module pulse_width_command_serializer_unit #(
   parameter int MAX_FRAME_BYTES = pwcs_pkg::MAX_FRAME_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   pwcs_chan_if.sink   req_if,
   pwcs_chan_if.source rsp_if,
   pwcs_chan_if.sink   csr_if
);

   localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int POS_W = $clog2(MAX_FRAME_BYTES);

   // Timing registers
   logic [15:0] ticks_per_unit_ff;
   logic [7:0]  lead_high_units_ff;
   logic [7:0]  lead_low_units_ff;
   logic [7:0]  long_units_ff;
   logic [7:0]  short_units_ff;

   // Frame state
   pwcs_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          frame_store [MAX_FRAME_BYTES];
   logic [LEN_W-1:0]    frame_length_ff, frame_length_in;
   logic [POS_W-1:0]    byte_position_ff, byte_position_in;
   logic [2:0]          bit_position_ff, bit_position_in;
   logic [7:0]          shift_byte_ff, shift_byte_in;
   logic [15:0]         prescale_count_ff, prescale_count_in;
   logic [7:0]          unit_count_ff, unit_count_in;
   logic                wire_level_ff, wire_level_in;

   // Output buffer
   pwcs_pkg::rsp_payload_type out_data_ff, skid_data_ff, result;
   logic out_valid_ff, skid_valid_ff;

   logic accept, start_ok, done, rejected;
   logic [7:0] cand [pwcs_pkg::FRAME_SLOTS];
   logic [2:0] cand_len;
   logic [1:0] data_n;
   logic       term_on;
   logic [7:0] term_byte;
   logic [16:0] prescale_inc;
   logic [8:0]  unit_inc;
   logic [15:0] units_now;
   logic [LEN_W:0] next_pos;

   assign req_if.ready = !skid_valid_ff;
   assign accept       = req_if.valid && req_if.ready;
   assign start_ok     = accept && (req_if.payload.cmd == pwcs_pkg::CMD_START)
                         && (phase_ff == pwcs_pkg::PH_IDLE);

   // Configuration writes
   assign csr_if.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_unit_ff  <= pwcs_pkg::TICKS_PER_UNIT_RST;
         lead_high_units_ff <= pwcs_pkg::LEAD_HIGH_UNITS_RST;
         lead_low_units_ff  <= pwcs_pkg::LEAD_LOW_UNITS_RST;
         long_units_ff      <= pwcs_pkg::LONG_UNITS_RST;
         short_units_ff     <= pwcs_pkg::SHORT_UNITS_RST;
      end else if (csr_if.valid) begin
         case (csr_if.payload.index)
            pwcs_pkg::REG_TICKS_PER_UNIT:  ticks_per_unit_ff  <= csr_if.payload.data;
            pwcs_pkg::REG_LEAD_HIGH_UNITS: lead_high_units_ff <= csr_if.payload.data[7:0];
            pwcs_pkg::REG_LEAD_LOW_UNITS:  lead_low_units_ff  <= csr_if.payload.data[7:0];
            pwcs_pkg::REG_LONG_UNITS:      long_units_ff      <= csr_if.payload.data[7:0];
            pwcs_pkg::REG_SHORT_UNITS:     short_units_ff     <= csr_if.payload.data[7:0];
            default: ;
         endcase
      end
   end

   // Build the candidate frame from a start item
   always_comb begin
      data_n = 2'd0;
      if (req_if.payload.byte_count == pwcs_pkg::COUNT_ONE) data_n = 2'd1;
      if (req_if.payload.byte_count == pwcs_pkg::COUNT_TWO) data_n = 2'd2;
      term_on   = 1'b1;
      term_byte = pwcs_pkg::CMD_END;
      case (req_if.payload.end_kind)
         pwcs_pkg::END_COMMAND: term_byte = pwcs_pkg::CMD_END;
         pwcs_pkg::END_PLAY:    term_byte = pwcs_pkg::PLAY_END;
         default:               term_on   = 1'b0;
      endcase
      cand[0]  = pwcs_pkg::LEAD_BYTE;
      cand[1]  = (data_n != 2'd0) ? req_if.payload.first_byte : term_byte;
      cand[2]  = (data_n == 2'd2) ? req_if.payload.second_byte : term_byte;
      cand[3]  = term_byte;
      cand_len = 3'd1 + {1'b0, data_n} + {2'b00, term_on};
   end

   // Write the frame store on an accepted start
   for (genvar i = 0; i < MAX_FRAME_BYTES; i++) begin : g_store
      if (i < pwcs_pkg::FRAME_SLOTS) begin : g_slot
         always_ff @(posedge clock) begin
            if (start_ok && (int'(cand_len) > i)) begin
               frame_store[i] <= cand[i];
            end
         end
      end
   end

   // Phase duration in units for the current bit or lead half
   always_comb begin
      case (phase_ff)
         pwcs_pkg::PH_LEAD_HIGH: units_now = {8'd0, lead_high_units_ff};
         pwcs_pkg::PH_LEAD_LOW:  units_now = {8'd0, lead_low_units_ff};
         pwcs_pkg::PH_BIT_HIGH:
            units_now = {8'd0, shift_byte_ff[0] ? long_units_ff : short_units_ff};
         default:
            units_now = {8'd0, shift_byte_ff[0] ? short_units_ff : long_units_ff};
      endcase
      units_now = pwcs_pkg::at_least_one(units_now);
   end

   // Next state for one item
   always_comb begin
      phase_in          = phase_ff;
      frame_length_in   = frame_length_ff;
      byte_position_in  = byte_position_ff;
      bit_position_in   = bit_position_ff;
      shift_byte_in     = shift_byte_ff;
      prescale_count_in = prescale_count_ff;
      unit_count_in     = unit_count_ff;
      wire_level_in     = wire_level_ff;
      done              = 1'b0;
      rejected          = 1'b0;
      prescale_inc      = {1'b0, prescale_count_ff} + 17'd1;
      unit_inc          = {1'b0, unit_count_ff} + 9'd1;
      next_pos          = (LEN_W+1)'(byte_position_ff) + (LEN_W+1)'(1);

      if (accept && req_if.payload.cmd == pwcs_pkg::CMD_START) begin
         if (phase_ff != pwcs_pkg::PH_IDLE) begin
            rejected = 1'b1;
         end else begin
            frame_length_in   = (int'(cand_len) > MAX_FRAME_BYTES) ?
                                LEN_W'(MAX_FRAME_BYTES) : LEN_W'(cand_len);
            byte_position_in  = '0;
            bit_position_in   = 3'd0;
            shift_byte_in     = pwcs_pkg::LEAD_BYTE;
            prescale_count_in = 16'd0;
            unit_count_in     = 8'd0;
            wire_level_in     = 1'b1;
            phase_in          = pwcs_pkg::PH_LEAD_HIGH;
         end
      end else if (accept && phase_ff != pwcs_pkg::PH_IDLE) begin
         prescale_count_in = prescale_inc[15:0];
         if (prescale_inc >= {1'b0, pwcs_pkg::at_least_one(ticks_per_unit_ff)}) begin
            prescale_count_in = 16'd0;
            unit_count_in     = unit_inc[7:0];
            if ({8'd0, unit_inc} >= {1'b0, units_now}) begin
               unit_count_in = 8'd0;
               // Advance to the next half, bit or byte, or end the frame
               case (phase_ff)
                  pwcs_pkg::PH_LEAD_HIGH: begin
                     phase_in      = pwcs_pkg::PH_LEAD_LOW;
                     wire_level_in = 1'b0;
                  end
                  pwcs_pkg::PH_LEAD_LOW: begin
                     phase_in        = pwcs_pkg::PH_BIT_HIGH;
                     bit_position_in = 3'd0;
                     wire_level_in   = 1'b1;
                  end
                  pwcs_pkg::PH_BIT_HIGH: begin
                     phase_in      = pwcs_pkg::PH_BIT_LOW;
                     wire_level_in = 1'b0;
                  end
                  default: begin
                     shift_byte_in = {1'b0, shift_byte_ff[7:1]};
                     wire_level_in = 1'b1;
                     if (bit_position_ff != 3'd7) begin
                        bit_position_in = bit_position_ff + 3'd1;
                        phase_in        = pwcs_pkg::PH_BIT_HIGH;
                     end else begin
                        bit_position_in = 3'd0;
                        if ((next_pos < (LEN_W+1)'(frame_length_ff)) &&
                            (int'(next_pos) < MAX_FRAME_BYTES)) begin
                           byte_position_in = next_pos[POS_W-1:0];
                           shift_byte_in    = frame_store[next_pos[POS_W-1:0]];
                           phase_in         = pwcs_pkg::PH_LEAD_HIGH;
                        end else begin
                           byte_position_in = '0;
                           phase_in         = pwcs_pkg::PH_IDLE;
                           done             = 1'b1;
                        end
                     end
                  end
               endcase
            end
         end
      end

      result.line_level     = wire_level_in;
      result.busy_res       = (phase_in != pwcs_pkg::PH_IDLE);
      result.frame_done     = done;
      result.start_rejected = rejected;
   end

   // Hold frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= pwcs_pkg::PH_IDLE;
         frame_length_ff   <= '0;
         byte_position_ff  <= '0;
         bit_position_ff   <= 3'd0;
         shift_byte_ff     <= 8'd0;
         prescale_count_ff <= 16'd0;
         unit_count_ff     <= 8'd0;
         wire_level_ff     <= 1'b1;
      end else begin
         phase_ff          <= phase_in;
         frame_length_ff   <= frame_length_in;
         byte_position_ff  <= byte_position_in;
         bit_position_ff   <= bit_position_in;
         shift_byte_ff     <= shift_byte_in;
         prescale_count_ff <= prescale_count_in;
         unit_count_ff     <= unit_count_in;
         wire_level_ff     <= wire_level_in;
      end
   end

   // Output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         if (!out_valid_ff || rsp_if.ready) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_valid_ff && rsp_if.ready) begin
         out_valid_ff  <= skid_valid_ff;
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (!out_valid_ff || rsp_if.ready) begin
            out_data_ff <= result;
         end else begin
            skid_data_ff <= result;
         end
      end else if (out_valid_ff && rsp_if.ready && skid_valid_ff) begin
         out_data_ff <= skid_data_ff;
      end
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_data_ff;

endmodule

[bench/pwcs_line_checker.sv]
`timescale 1ns / 100ps
// Line checker for the pulse-width command serializer: predicts every result item
// from the accepted request and register items and compares field by field.
// Depends on pwcs_pkg only; the testbench top connects it to the channel signals.
module pwcs_line_checker #(
   parameter int FRAME_DEPTH = pwcs_pkg::MAX_FRAME_BYTES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  pwcs_pkg::req_payload_type req_item,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  pwcs_pkg::rsp_payload_type rsp_item,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  pwcs_pkg::csr_payload_type csr_item,
   output int                        fail_count,
   output int                        open_results
);

   // Timing registers as the block should hold them
   logic [15:0] tick_div;
   logic [7:0]  lead_hi_units;
   logic [7:0]  lead_lo_units;
   logic [7:0]  long_half;
   logic [7:0]  short_half;

   // Serializer state
   pwcs_pkg::phase_type line_phase;
   logic [7:0]  frame_bytes [FRAME_DEPTH];
   int unsigned frame_len;
   int unsigned byte_idx;
   int unsigned bit_idx;
   logic [7:0]  shift_reg;
   int unsigned prescale;
   int unsigned unit_cnt;
   logic        wire_q;

   // Results still owed by the block, oldest first
   pwcs_pkg::rsp_payload_type line_results_due[$];

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // Zero counts act as one
   function automatic int unsigned floor_one(input int unsigned v);
      return (v == 0) ? 1 : v;
   endfunction

   // Length in units of the phase the line is in
   function automatic int unsigned hold_units();
      int unsigned n;
      case (line_phase)
         pwcs_pkg::PH_LEAD_HIGH: n = lead_hi_units;
         pwcs_pkg::PH_LEAD_LOW:  n = lead_lo_units;
         pwcs_pkg::PH_BIT_HIGH:  n = shift_reg[0] ? long_half : short_half;
         default:                n = shift_reg[0] ? short_half : long_half;
      endcase
      return floor_one(n);
   endfunction

   function automatic void add_frame_byte(input logic [7:0] b);
      if (frame_len < FRAME_DEPTH) begin
         frame_bytes[frame_len] = b;
         frame_len++;
      end
   endfunction

   // Advance to the next phase when the current one runs out; flag frame end
   function automatic bit step_phase();
      bit ended;
      ended = 1'b0;
      case (line_phase)
         pwcs_pkg::PH_LEAD_HIGH: begin
            line_phase = pwcs_pkg::PH_LEAD_LOW;
            wire_q = 1'b0;
         end
         pwcs_pkg::PH_LEAD_LOW: begin
            line_phase = pwcs_pkg::PH_BIT_HIGH;
            bit_idx = 0;
            wire_q = 1'b1;
         end
         pwcs_pkg::PH_BIT_HIGH: begin
            line_phase = pwcs_pkg::PH_BIT_LOW;
            wire_q = 1'b0;
         end
         default: begin
            shift_reg = shift_reg >> 1;
            wire_q = 1'b1;
            if (bit_idx < 7) begin
               bit_idx++;
               line_phase = pwcs_pkg::PH_BIT_HIGH;
            end else begin
               bit_idx = 0;
               byte_idx++;
               if (byte_idx < frame_len && byte_idx < FRAME_DEPTH) begin
                  shift_reg = frame_bytes[byte_idx];
                  line_phase = pwcs_pkg::PH_LEAD_HIGH;
               end else begin
                  line_phase = pwcs_pkg::PH_IDLE;
                  byte_idx = 0;
                  ended = 1'b1;
               end
            end
         end
      endcase
      return ended;
   endfunction

   // Work out the line result that one request item causes
   function automatic pwcs_pkg::rsp_payload_type predict_line(
      input pwcs_pkg::req_payload_type it);
      pwcs_pkg::rsp_payload_type res;
      bit ended;
      bit rejected;
      ended = 1'b0;
      rejected = 1'b0;
      if (it.cmd == pwcs_pkg::CMD_START) begin
         if (line_phase != pwcs_pkg::PH_IDLE) begin
            rejected = 1'b1;
         end else begin
            frame_len = 0;
            add_frame_byte(pwcs_pkg::LEAD_BYTE);
            if (it.byte_count == pwcs_pkg::COUNT_ONE || it.byte_count == pwcs_pkg::COUNT_TWO)
               add_frame_byte(it.first_byte);
            if (it.byte_count == pwcs_pkg::COUNT_TWO)
               add_frame_byte(it.second_byte);
            if (it.end_kind == pwcs_pkg::END_COMMAND)
               add_frame_byte(pwcs_pkg::CMD_END);
            else if (it.end_kind == pwcs_pkg::END_PLAY)
               add_frame_byte(pwcs_pkg::PLAY_END);
            byte_idx = 0;
            bit_idx = 0;
            shift_reg = frame_bytes[0];
            prescale = 0;
            unit_cnt = 0;
            wire_q = 1'b1;
            line_phase = pwcs_pkg::PH_LEAD_HIGH;
         end
      end else if (line_phase != pwcs_pkg::PH_IDLE) begin
         prescale++;
         if (prescale >= floor_one(tick_div)) begin
            prescale = 0;
            unit_cnt++;
            if (unit_cnt >= hold_units()) begin
               unit_cnt = 0;
               ended = step_phase();
            end
         end
      end
      res.line_level     = wire_q;
      res.busy_res       = (line_phase != pwcs_pkg::PH_IDLE);
      res.frame_done     = ended;
      res.start_rejected = rejected;
      return res;
   endfunction

   function automatic void write_timing(input pwcs_pkg::csr_payload_type w);
      case (pwcs_pkg::reg_index_type'(w.index))
         pwcs_pkg::REG_TICKS_PER_UNIT:  tick_div = w.data;
         pwcs_pkg::REG_LEAD_HIGH_UNITS: lead_hi_units = w.data[7:0];
         pwcs_pkg::REG_LEAD_LOW_UNITS:  lead_lo_units = w.data[7:0];
         pwcs_pkg::REG_LONG_UNITS:      long_half = w.data[7:0];
         pwcs_pkg::REG_SHORT_UNITS:     short_half = w.data[7:0];
         default: ;
      endcase
   endfunction

   // Track registers and requests, then match each result against the oldest one owed
   always @(posedge clock) begin : watch
      pwcs_pkg::rsp_payload_type due;
      if (reset) begin
         tick_div      = pwcs_pkg::TICKS_PER_UNIT_RST;
         lead_hi_units = pwcs_pkg::LEAD_HIGH_UNITS_RST;
         lead_lo_units = pwcs_pkg::LEAD_LOW_UNITS_RST;
         long_half     = pwcs_pkg::LONG_UNITS_RST;
         short_half    = pwcs_pkg::SHORT_UNITS_RST;
         line_phase    = pwcs_pkg::PH_IDLE;
         frame_len     = 0;
         byte_idx      = 0;
         bit_idx       = 0;
         shift_reg     = '0;
         prescale      = 0;
         unit_cnt      = 0;
         wire_q        = 1'b1;
         fail_count    = 0;
         line_results_due.delete();
      end else begin
         if (csr_valid && csr_ready)
            write_timing(csr_item);
         if (req_valid && req_ready)
            line_results_due.push_back(predict_line(req_item));
         if (rsp_valid && rsp_ready) begin
            if (line_results_due.size() == 0) begin
               report_mismatch("result item with nothing expected");
            end else begin
               due = line_results_due.pop_front();
               if (rsp_item.line_level !== due.line_level)
                  report_mismatch($sformatf("line_level %b, expected %b",
                                            rsp_item.line_level, due.line_level));
               if (rsp_item.busy_res !== due.busy_res)
                  report_mismatch($sformatf("busy_res %b, expected %b",
                                            rsp_item.busy_res, due.busy_res));
               if (rsp_item.frame_done !== due.frame_done)
                  report_mismatch($sformatf("frame_done %b, expected %b",
                                            rsp_item.frame_done, due.frame_done));
               if (rsp_item.start_rejected !== due.start_rejected)
                  report_mismatch($sformatf("start_rejected %b, expected %b",
                                            rsp_item.start_rejected, due.start_rejected));
            end
         end
      end
      open_results <= line_results_due.size();
   end

endmodule

[bench/pulse_width_command_serializer_unit_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the pulse-width command serializer: clock, reset, stimulus, verdict.
// Depends on pwcs_pkg, pwcs_chan_if, the serializer RTL and pwcs_line_checker.
module pulse_width_command_serializer_unit_tb;

   // Field codes the package leaves unnamed
   localparam logic [1:0] COUNT_NONE = 2'd0;
   localparam logic [1:0] COUNT_BAD  = 2'd3;
   localparam logic [1:0] END_NONE   = 2'd2;
   localparam logic [1:0] END_BAD    = 2'd3;

   logic clock;
   logic reset;
   int   gap_pct;
   int   stall_pct;
   logic last_busy;
   int   fail_count;
   int   open_results;

   pwcs_chan_if #(.payload_type(pwcs_pkg::req_payload_type)) req_if ();
   pwcs_chan_if #(.payload_type(pwcs_pkg::rsp_payload_type)) rsp_if ();
   pwcs_chan_if #(.payload_type(pwcs_pkg::csr_payload_type)) csr_if ();

   pulse_width_command_serializer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   pwcs_line_checker line_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_if.valid),
      .req_ready    (req_if.ready),
      .req_item     (req_if.payload),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .rsp_item     (rsp_if.payload),
      .csr_valid    (csr_if.valid),
      .csr_ready    (csr_if.ready),
      .csr_item     (csr_if.payload),
      .fail_count   (fail_count),
      .open_results (open_results)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stall the result side at random; remember busy from the latest result item
   always @(posedge clock) begin
      rsp_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      if (reset)
         last_busy <= 1'b0;
      else if (rsp_if.valid && rsp_if.ready)
         last_busy <= rsp_if.payload.busy_res;
   end

   function automatic pwcs_pkg::req_payload_type any_item(input logic cmd);
      pwcs_pkg::req_payload_type it;
      it.cmd         = cmd;
      it.first_byte  = 8'($urandom_range(255));
      it.second_byte = 8'($urandom_range(255));
      it.byte_count  = 2'($urandom_range(3));
      it.end_kind    = 2'($urandom_range(3));
      return it;
   endfunction

   function automatic pwcs_pkg::req_payload_type start_item(input logic [1:0] count,
                                                            input logic [1:0] kind,
                                                            input logic [7:0] b0,
                                                            input logic [7:0] b1);
      pwcs_pkg::req_payload_type it;
      it.cmd         = pwcs_pkg::CMD_START;
      it.first_byte  = b0;
      it.second_byte = b1;
      it.byte_count  = count;
      it.end_kind    = kind;
      return it;
   endfunction

   // Short unit count in the low byte, junk in the ignored high byte
   function automatic logic [15:0] unit_word();
      logic [15:0] w;
      w[15:8] = 8'($urandom_range(255));
      w[7:0]  = 8'($urandom_range(3));
      return w;
   endfunction

   // Offer one item, idling at random first, and hold it until taken
   task automatic send_item(input pwcs_pkg::req_payload_type it);
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= it;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Drop valid and wait for every owed result item
   task automatic hold_until_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (open_results != 0) @(posedge clock);
   endtask

   task automatic write_reg(input pwcs_pkg::reg_index_type idx, input logic [15:0] value);
      pwcs_pkg::csr_payload_type w;
      w.index = idx;
      w.data  = value;
      csr_if.valid   <= 1'b1;
      csr_if.payload <= w;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_timing(input logic [15:0] div, input logic [15:0] lead_hi,
                              input logic [15:0] lead_lo, input logic [15:0] long_u,
                              input logic [15:0] short_u);
      hold_until_drained();
      write_reg(pwcs_pkg::REG_TICKS_PER_UNIT, div);
      write_reg(pwcs_pkg::REG_LEAD_HIGH_UNITS, lead_hi);
      write_reg(pwcs_pkg::REG_LEAD_LOW_UNITS, lead_lo);
      write_reg(pwcs_pkg::REG_LONG_UNITS, long_u);
      write_reg(pwcs_pkg::REG_SHORT_UNITS, short_u);
   endtask

   // Tick until the frame in flight has gone out and the line is idle
   task automatic run_out_frame();
      hold_until_drained();
      while (last_busy) send_item(any_item(pwcs_pkg::CMD_TICK));
      hold_until_drained();
   endtask

   // Mostly ticks; start frames when idle, now and then a start into a busy line
   task automatic random_burst(input int n);
      for (int k = 0; k < n; k++) begin
         if (!last_busy && $urandom_range(99) < 40)
            send_item(any_item(pwcs_pkg::CMD_START));
         else if ($urandom_range(99) < 3)
            send_item(any_item(pwcs_pkg::CMD_START));
         else
            send_item(any_item(pwcs_pkg::CMD_TICK));
      end
   endtask

   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      gap_pct        = 9;
      stall_pct      = 9;
      reset          = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Ticks into an idle line under reset timing
      send_item(any_item(pwcs_pkg::CMD_TICK));
      send_item(any_item(pwcs_pkg::CMD_TICK));

      // Fast prescaler, unit counts left at their reset values
      hold_until_drained();
      write_reg(pwcs_pkg::REG_TICKS_PER_UNIT, 16'd1);
      send_item(start_item(pwcs_pkg::COUNT_TWO, pwcs_pkg::END_COMMAND, 8'hFF, 8'h00));
      repeat (3) send_item(any_item(pwcs_pkg::CMD_TICK));
      send_item(any_item(pwcs_pkg::CMD_START));
      run_out_frame();

      // All registers zero: every count acts as one
      load_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_item(start_item(pwcs_pkg::COUNT_TWO, pwcs_pkg::END_COMMAND, 8'h01, 8'h80));
      run_out_frame();
      send_item(start_item(pwcs_pkg::COUNT_ONE, pwcs_pkg::END_PLAY, 8'h5A, 8'hA5));
      run_out_frame();
      send_item(start_item(COUNT_NONE, END_NONE, 8'h00, 8'hFF));
      run_out_frame();
      send_item(start_item(COUNT_BAD, END_BAD, 8'hC3, 8'h3C));
      run_out_frame();

      // Widest lead count with the lead byte alone
      load_timing(16'd1, 16'd255, 16'd1, 16'd1, 16'd0);
      send_item(start_item(COUNT_NONE, END_NONE, 8'hAA, 8'h55));
      run_out_frame();

      // Random phases over small timing settings; one with no idling at all
      for (int p = 0; p < 6; p++) begin
         load_timing(16'($urandom_range(2)), unit_word(), unit_word(), unit_word(),
                     unit_word());
         gap_pct   = (p == 2) ? 0 : 9;
         stall_pct = (p == 2) ? 0 : 9;
         random_burst(30);
         hold_until_drained();
         random_burst(35);
         run_out_frame();
      end
      gap_pct   = 9;
      stall_pct = 9;

      // Slowest prescaler: the frame stays in its first phase to the end
      load_timing(16'hFFFF, 16'h0003, 16'h0003, 16'h0002, 16'h0001);
      send_item(start_item(pwcs_pkg::COUNT_TWO, pwcs_pkg::END_PLAY,
                           8'($urandom_range(255)), 8'($urandom_range(255))));
      random_burst(60);

      hold_until_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Give up on a hung run
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

[sim.f]
rtl/pwcs_pkg.sv
rtl/pwcs_chan_if.sv
rtl/pulse_width_command_serializer_unit.sv
bench/pwcs_line_checker.sv
bench/pulse_width_command_serializer_unit_tb.sv
